>>> rtl/dbbd_pkg.sv
// Shared types and constants of the DRAM bank burst dispatcher.
`default_nettype none
package dbbd_pkg;

  localparam int unsigned BANK_W       = 2;
  localparam int unsigned BEATS_W      = 7;
  localparam int unsigned DATA_FIELD_W = 64;

  localparam int unsigned BEATS_LOG2_DEF = 6;
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_RD_CTX  = 2'd0,
    FUNC_WR_CTX  = 2'd1,
    FUNC_RD_BEAT = 2'd2,
    FUNC_WR_BEAT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_TO_REQ  = 2'd1,
    KIND_TO_BANK = 2'd2
  } kind_e;

  // classified item as it sits in the queue
  typedef struct packed {
    func_e                   op;
    logic [BANK_W-1:0]       bank;
    logic [BANK_W-1:0]       end_bank;
    logic [BEATS_W-1:0]      total_beats;
    logic [BEATS_W-1:0]      split_beats;
    logic [DATA_FIELD_W-1:0] beat_data;
    logic                    beat_last;
  } entry_t;

  typedef struct packed {
    logic                    accepted;
    kind_e                   out_kind;
    logic [BANK_W-1:0]       out_bank;
    logic [DATA_FIELD_W-1:0] out_data;
    logic                    out_last;
    logic                    read_busy;
    logic                    write_busy;
  } result_t;

  // front <-> queue handshake
  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic   full;
    logic   empty;
  } q_stat_t;

endpackage
`default_nettype wire

>>> rtl/dbbd_ifs.sv
// Item and result channel interfaces of the DRAM bank burst dispatcher.
`default_nettype none
interface dbbd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            func;
  logic [dbbd_pkg::BANK_W-1:0]           bank;
  logic [dbbd_pkg::BANK_W-1:0]           end_bank;
  logic [dbbd_pkg::BEATS_W-1:0]          total_beats;
  logic [dbbd_pkg::BEATS_W-1:0]          split_beats;
  logic [dbbd_pkg::DATA_FIELD_W-1:0]     beat_data;
  logic                                  beat_last;

  modport source (
    output valid, func, bank, end_bank, total_beats, split_beats, beat_data, beat_last,
    input  ready
  );
  modport sink (
    input  valid, func, bank, end_bank, total_beats, split_beats, beat_data, beat_last,
    output ready
  );
endinterface

interface dbbd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  accepted;
  logic [1:0]                            out_kind;
  logic [dbbd_pkg::BANK_W-1:0]           out_bank;
  logic [dbbd_pkg::DATA_FIELD_W-1:0]     out_data;
  logic                                  out_last;
  logic                                  read_busy;
  logic                                  write_busy;

  modport source (
    output valid, accepted, out_kind, out_bank, out_data, out_last, read_busy, write_busy,
    input  ready
  );
  modport sink (
    input  valid, accepted, out_kind, out_bank, out_data, out_last, read_busy, write_busy,
    output ready
  );
endinterface
`default_nettype wire

>>> rtl/dbbd_front.sv
// Front end: takes items from the input channel, decodes and masks them for the queue.
`default_nettype none
module dbbd_front #(
  parameter int unsigned DATA_WIDTH = dbbd_pkg::DATA_WIDTH_DEF
) (
  dbbd_in_if.sink           in_i,
  input  dbbd_pkg::q_stat_t q_stat_i,
  output dbbd_pkg::q_push_t q_push_o
);

  assign in_i.ready = !q_stat_i.full;

  always_comb begin
    q_push_o.push              = in_i.valid && !q_stat_i.full;
    q_push_o.entry.op          = dbbd_pkg::func_e'(in_i.func);
    q_push_o.entry.bank        = in_i.bank;
    q_push_o.entry.end_bank    = in_i.end_bank;
    q_push_o.entry.total_beats = in_i.total_beats;
    q_push_o.entry.split_beats = in_i.split_beats;
    // beat payload narrowed to the configured data width
    q_push_o.entry.beat_data   = dbbd_pkg::DATA_FIELD_W'(in_i.beat_data[DATA_WIDTH-1:0]);
    q_push_o.entry.beat_last   = in_i.beat_last;
  end

endmodule
`default_nettype wire

>>> rtl/dbbd_queue.sv
// Short FIFO between the front end and the dispatch engines.
`default_nettype none
module dbbd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dbbd_pkg::q_push_t q_push_i,
  input  logic              pop_i,
  output dbbd_pkg::q_stat_t q_stat_o,
  output dbbd_pkg::entry_t  head_o
);

  localparam int unsigned Depth = dbbd_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dbbd_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = q_push_i.push && (cnt_q != CntW'(Depth));
  assign do_pop  = pop_i && (cnt_q != '0);

  assign q_stat_o.full  = (cnt_q == CntW'(Depth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_push_i.entry;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dbbd_engine.sv
// Back end: read and write engines and the registered result stage.
`default_nettype none
module dbbd_engine #(
  parameter int unsigned BEATS_LOG2 = dbbd_pkg::BEATS_LOG2_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dbbd_pkg::q_stat_t q_stat_i,
  input  dbbd_pkg::entry_t  head_i,
  output logic              pop_o,
  dbbd_out_if.source        out_o
);

  localparam int unsigned CntW = BEATS_LOG2 + 1;
  localparam int unsigned ExtW = CntW + dbbd_pkg::BEATS_W;

  typedef logic [dbbd_pkg::BANK_W-1:0] bank_t;
  typedef logic [CntW-1:0]             cnt_t;

  logic  rd_active_q, rd_active_d, rd_after_q, rd_after_d;
  bank_t rd_start_q, rd_start_d, rd_end_q, rd_end_d;
  cnt_t  rd_total_q, rd_total_d, rd_count_q, rd_count_d;
  logic  wr_active_q, wr_active_d, wr_after_q, wr_after_d;
  bank_t wr_start_q, wr_start_d, wr_end_q, wr_end_d;
  cnt_t  wr_total_q, wr_total_d, wr_split_q, wr_split_d, wr_count_q, wr_count_d;

  dbbd_pkg::result_t res_q, res_d;
  logic              res_valid_q;

  logic [ExtW-1:0] total_ext, split_ext;
  cnt_t            total_c, split_c, rd_inc, wr_inc;
  bank_t           rd_cur, wr_cur;

  // counts wrap at the counter width; wider fields are truncated
  assign total_ext = {{CntW{1'b0}}, head_i.total_beats};
  assign split_ext = {{CntW{1'b0}}, head_i.split_beats};
  assign total_c   = total_ext[CntW-1:0];
  assign split_c   = split_ext[CntW-1:0];
  assign rd_inc    = rd_count_q + 1'b1;
  assign wr_inc    = wr_count_q + 1'b1;
  assign rd_cur    = rd_after_q ? rd_end_q : rd_start_q;
  assign wr_cur    = wr_after_q ? wr_end_q : wr_start_q;

  assign pop_o = !q_stat_i.empty && (!res_valid_q || out_o.ready);

  always_comb begin
    rd_active_d = rd_active_q;
    rd_after_d  = rd_after_q;
    rd_start_d  = rd_start_q;
    rd_end_d    = rd_end_q;
    rd_total_d  = rd_total_q;
    rd_count_d  = rd_count_q;
    wr_active_d = wr_active_q;
    wr_after_d  = wr_after_q;
    wr_start_d  = wr_start_q;
    wr_end_d    = wr_end_q;
    wr_total_d  = wr_total_q;
    wr_split_d  = wr_split_q;
    wr_count_d  = wr_count_q;
    res_d       = '0;
    res_d.out_kind = dbbd_pkg::KIND_NONE;

    case (head_i.op)
      dbbd_pkg::FUNC_RD_CTX: begin
        if (!rd_active_q) begin
          rd_active_d    = 1'b1;
          rd_after_d     = 1'b0;
          rd_start_d     = head_i.bank;
          rd_end_d       = head_i.end_bank;
          rd_total_d     = total_c;
          res_d.accepted = 1'b1;
        end
      end
      dbbd_pkg::FUNC_WR_CTX: begin
        if (!wr_active_q) begin
          wr_active_d    = 1'b1;
          wr_after_d     = 1'b0;
          wr_start_d     = head_i.bank;
          wr_end_d       = head_i.end_bank;
          wr_total_d     = total_c;
          wr_split_d     = split_c;
          wr_count_d     = '0;
          res_d.accepted = 1'b1;
        end
      end
      dbbd_pkg::FUNC_RD_BEAT: begin
        if (rd_active_q && head_i.bank == rd_cur) begin
          rd_count_d     = rd_inc;
          res_d.out_last = head_i.beat_last;
          if (head_i.beat_last && rd_inc < rd_total_q) begin
            // early last: hide it and move on to the end bank
            rd_after_d     = 1'b1;
            res_d.out_last = 1'b0;
          end else if (head_i.beat_last && rd_inc == rd_total_q) begin
            rd_active_d = 1'b0;
            rd_after_d  = 1'b0;
            rd_count_d  = '0;
          end
          res_d.accepted = 1'b1;
          res_d.out_kind = dbbd_pkg::KIND_TO_REQ;
          res_d.out_data = head_i.beat_data;
        end
      end
      dbbd_pkg::FUNC_WR_BEAT: begin
        if (wr_active_q) begin
          wr_count_d     = wr_inc;
          res_d.out_last = head_i.beat_last;
          if (head_i.beat_last && wr_inc == wr_total_q) begin
            wr_active_d = 1'b0;
            wr_after_d  = 1'b0;
            wr_count_d  = '0;
          end else if (!wr_after_q && wr_inc == wr_split_q) begin
            // split boundary: force last, later beats go to the end bank
            res_d.out_last = 1'b1;
            wr_after_d     = 1'b1;
          end
          res_d.accepted = 1'b1;
          res_d.out_kind = dbbd_pkg::KIND_TO_BANK;
          res_d.out_bank = wr_cur;
          res_d.out_data = head_i.beat_data;
        end
      end
      default: begin
        res_d = '0;
      end
    endcase

    res_d.read_busy  = rd_active_d;
    res_d.write_busy = wr_active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_active_q <= 1'b0;
      rd_after_q  <= 1'b0;
      rd_start_q  <= '0;
      rd_end_q    <= '0;
      rd_total_q  <= '0;
      rd_count_q  <= '0;
      wr_active_q <= 1'b0;
      wr_after_q  <= 1'b0;
      wr_start_q  <= '0;
      wr_end_q    <= '0;
      wr_total_q  <= '0;
      wr_split_q  <= '0;
      wr_count_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        rd_active_q <= rd_active_d;
        rd_after_q  <= rd_after_d;
        rd_start_q  <= rd_start_d;
        rd_end_q    <= rd_end_d;
        rd_total_q  <= rd_total_d;
        rd_count_q  <= rd_count_d;
        wr_active_q <= wr_active_d;
        wr_after_q  <= wr_after_d;
        wr_start_q  <= wr_start_d;
        wr_end_q    <= wr_end_d;
        wr_total_q  <= wr_total_d;
        wr_split_q  <= wr_split_d;
        wr_count_q  <= wr_count_d;
      end
      if (pop_o) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.accepted   = res_q.accepted;
  assign out_o.out_kind   = res_q.out_kind;
  assign out_o.out_bank   = res_q.out_bank;
  assign out_o.out_data   = res_q.out_data;
  assign out_o.out_last   = res_q.out_last;
  assign out_o.read_busy  = res_q.read_busy;
  assign out_o.write_busy = res_q.write_busy;

  // an idle engine keeps its count at zero and its boundary flag clear
  a_rd_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rd_active_q |-> (rd_count_q == '0 && !rd_after_q))
    else $error("read engine idle with stale count or boundary flag");

  a_wr_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_active_q |-> (wr_count_q == '0 && !wr_after_q))
    else $error("write engine idle with stale count or boundary flag");

  a_busy_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (res_q.read_busy == rd_active_q && res_q.write_busy == wr_active_q))
    else $error("busy flags of result disagree with engine state");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (res_q.out_kind != dbbd_pkg::KIND_NONE ||
               (res_q.out_data == '0 && !res_q.out_last && res_q.out_bank == '0)))
    else $error("payload on a result that forwards nothing");

endmodule
`default_nettype wire

>>> rtl/dram_bank_burst_dispatcher_unit.sv
// Top level of the DRAM bank burst dispatcher.
//
//   channel | dir | handshake          | carries
//   --------+-----+--------------------+-------------------------------------------
//   in_i    | in  | valid/ready        | func, bank, end_bank, counts, beat, last
//   out_o   | out | valid/ready        | accepted, kind, bank, data, last, busy
//
// One item per cycle sustained while the output takes results; each item passes
// through the queue, then its result is held in the result register.
// The engine state is updated in the cycle an item leaves the queue.
// Reset is asynchronous, active low; both engines come up idle.
// A stalled output holds the result register; the two-entry queue keeps
// taking items until it fills.
`default_nettype none
module dram_bank_burst_dispatcher_unit #(
  parameter int unsigned BEATS_LOG2 = dbbd_pkg::BEATS_LOG2_DEF,
  parameter int unsigned DATA_WIDTH = dbbd_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dbbd_in_if.sink     in_i,
  dbbd_out_if.source  out_o
);

  dbbd_pkg::q_push_t q_push;
  dbbd_pkg::q_stat_t q_stat;
  dbbd_pkg::entry_t  q_head;
  logic              q_pop;

  dbbd_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push)
  );

  dbbd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_push_i (q_push),
    .pop_i    (q_pop),
    .q_stat_o (q_stat),
    .head_o   (q_head)
  );

  dbbd_engine #(
    .BEATS_LOG2 (BEATS_LOG2)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .head_i   (q_head),
    .pop_o    (q_pop),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire

>>> verif/dbbd_burst_checker.sv
// Result predictor and scoreboard for the DRAM bank burst dispatcher.
`timescale 1ns / 100ps
module dbbd_burst_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dbbd_in_if   in_ch,
  dbbd_out_if  out_ch,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  import dbbd_pkg::*;

  localparam int unsigned CNT_W = BEATS_LOG2_DEF + 1;
  localparam int REPORT_MAX = 10;

  // read engine
  logic              rd_on, rd_late;
  logic [BANK_W-1:0] rd_first, rd_final;
  logic [CNT_W-1:0]  rd_goal, rd_beats;
  // write engine
  logic              wr_on, wr_late;
  logic [BANK_W-1:0] wr_first, wr_final;
  logic [CNT_W-1:0]  wr_goal, wr_cut, wr_beats;

  result_t route_q[$];

  function automatic result_t route_item(input entry_t it);
    result_t           r;
    logic [BANK_W-1:0] cur;
    logic              ol;
    r = '0;
    case (it.op)
      FUNC_RD_CTX: begin
        if (!rd_on) begin
          rd_on    = 1'b1;
          rd_late  = 1'b0;
          rd_first = it.bank;
          rd_final = it.end_bank;
          rd_goal  = it.total_beats[CNT_W-1:0];
          r.accepted = 1'b1;
        end
      end
      FUNC_WR_CTX: begin
        if (!wr_on) begin
          wr_on    = 1'b1;
          wr_late  = 1'b0;
          wr_first = it.bank;
          wr_final = it.end_bank;
          wr_goal  = it.total_beats[CNT_W-1:0];
          wr_cut   = it.split_beats[CNT_W-1:0];
          wr_beats = '0;
          r.accepted = 1'b1;
        end
      end
      FUNC_RD_BEAT: begin
        cur = rd_late ? rd_final : rd_first;
        if (rd_on && it.bank == cur) begin
          ol = it.beat_last;
          rd_beats = rd_beats + 1'b1;
          if (it.beat_last && rd_beats < rd_goal) begin
            // early last: hide it and move on to the end bank
            rd_late = 1'b1;
            ol = 1'b0;
          end else if (it.beat_last && rd_beats == rd_goal) begin
            rd_on    = 1'b0;
            rd_late  = 1'b0;
            rd_beats = '0;
          end
          r.accepted = 1'b1;
          r.out_kind = KIND_TO_REQ;
          r.out_data = it.beat_data;
          r.out_last = ol;
        end
      end
      default: begin
        if (wr_on) begin
          cur = wr_late ? wr_final : wr_first;
          ol = it.beat_last;
          wr_beats = wr_beats + 1'b1;
          if (it.beat_last && wr_beats == wr_goal) begin
            wr_on    = 1'b0;
            wr_late  = 1'b0;
            wr_beats = '0;
          end else if (!wr_late && wr_beats == wr_cut) begin
            // boundary reached: force last, later beats go to the end bank
            ol = 1'b1;
            wr_late = 1'b1;
          end
          r.accepted = 1'b1;
          r.out_kind = KIND_TO_BANK;
          r.out_bank = cur;
          r.out_data = it.beat_data;
          r.out_last = ol;
        end
      end
    endcase
    r.read_busy  = rd_on;
    r.write_busy = wr_on;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, exp;
    entry_t  taken;
    if (!rst_ni) begin
      rd_on = 1'b0; rd_late = 1'b0; rd_first = '0; rd_final = '0;
      rd_goal = '0; rd_beats = '0;
      wr_on = 1'b0; wr_late = 1'b0; wr_first = '0; wr_final = '0;
      wr_goal = '0; wr_cut = '0; wr_beats = '0;
      route_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // compare before queuing: a result never belongs to the item taken this edge
      if (out_ch.valid && out_ch.ready) begin
        got.accepted   = out_ch.accepted;
        got.out_kind   = kind_e'(out_ch.out_kind);
        got.out_bank   = out_ch.out_bank;
        got.out_data   = out_ch.out_data;
        got.out_last   = out_ch.out_last;
        got.read_busy  = out_ch.read_busy;
        got.write_busy = out_ch.write_busy;
        if (route_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("ERROR result %0d arrived with nothing outstanding: acc=%0b kind=%0d",
                     checked_o, got.accepted, got.out_kind);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp = route_q.pop_front();
          if (got !== exp) begin
            if (fail_count_o < REPORT_MAX) begin
              $display("ERROR result %0d exp: acc=%0b kind=%0d bank=%0d data=%h last=%0b rb=%0b wb=%0b",
                       checked_o, exp.accepted, exp.out_kind, exp.out_bank, exp.out_data,
                       exp.out_last, exp.read_busy, exp.write_busy);
              $display("ERROR result %0d got: acc=%0b kind=%0d bank=%0d data=%h last=%0b rb=%0b wb=%0b",
                       checked_o, got.accepted, got.out_kind, got.out_bank, got.out_data,
                       got.out_last, got.read_busy, got.write_busy);
            end
            fail_count_o <= fail_count_o + 1;
          end
        end
        checked_o <= checked_o + 1;
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.op          = func_e'(in_ch.func);
        taken.bank        = in_ch.bank;
        taken.end_bank    = in_ch.end_bank;
        taken.total_beats = in_ch.total_beats;
        taken.split_beats = in_ch.split_beats;
        taken.beat_data   = in_ch.beat_data;
        taken.beat_last   = in_ch.beat_last;
        route_q.push_back(route_item(taken));
      end
      pending_o <= route_q.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// Stimulus and verdict for the DRAM bank burst dispatcher.
`timescale 1ns / 100ps
module tb_top;
  import dbbd_pkg::*;

  localparam int WORK_ITEMS     = 600;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  dbbd_in_if  in_ch ();
  dbbd_out_if out_ch ();

  int fail_count, pending, checked;

  dram_bank_burst_dispatcher_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  dbbd_burst_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // beats still owed to each engine, next one at the front
  entry_t rd_plan[$];
  entry_t wr_plan[$];

  int send_idle;
  int recv_idle;
  int hold_asks;
  int phase;
  bit wrapped;
  int work_items, ignored_items, read_xfers, write_xfers;

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // watchdog: too long without any item moving
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else if (rst_ni) begin
        quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
          $display("ERROR no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("dram_bank_burst_dispatcher_unit: mismatch");
          $finish;
        end
      end
    end
  end

  function automatic entry_t rand_item(input func_e op);
    entry_t it;
    it.op          = op;
    it.bank        = 2'($urandom_range(0, 3));
    it.end_bank    = 2'($urandom_range(0, 3));
    it.total_beats = 7'($urandom_range(0, 127));
    it.split_beats = 7'($urandom_range(0, 127));
    it.beat_data   = {$urandom, $urandom};
    it.beat_last   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [BEATS_W-1:0] pick_total();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 1) return '0;
    if (sel < 4) return 7'($urandom_range(9, 127));
    return 7'($urandom_range(1, 8));
  endfunction

  task automatic send_item(input entry_t it, input bit ignored);
    if (send_idle > 0) begin
      while ($urandom_range(0, 99) < send_idle) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= it.op;
    in_ch.bank        <= it.bank;
    in_ch.end_bank    <= it.end_bank;
    in_ch.total_beats <= it.total_beats;
    in_ch.split_beats <= it.split_beats;
    in_ch.beat_data   <= it.beat_data;
    in_ch.beat_last   <= it.beat_last;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    if (ignored) ignored_items++;
    else work_items++;
  endtask

  // k is the beat that carries the early last; k == t means no switch
  task automatic start_read(input logic [1:0] s, input logic [1:0] e,
                            input logic [BEATS_W-1:0] t, input int k);
    entry_t ctx, b;
    int     n;
    ctx = rand_item(FUNC_RD_CTX);
    ctx.bank        = s;
    ctx.end_bank    = e;
    ctx.total_beats = t;
    send_item(ctx, 1'b0);
    read_xfers++;
    // a zero total only ends once the count wraps around
    n = (t == 0) ? 128 : t;
    for (int c = 1; c <= n; c++) begin
      b = rand_item(FUNC_RD_BEAT);
      if (t == 0) begin
        b.bank      = s;
        b.beat_last = (c == n) || ($urandom_range(0, 1) == 1);
      end else begin
        b.bank      = (c <= k) ? s : e;
        b.beat_last = (c == k) || (c == n) || (c > k && $urandom_range(0, 3) == 0);
      end
      rd_plan.push_back(b);
    end
  endtask

  task automatic start_write(input logic [1:0] s, input logic [1:0] e,
                             input logic [BEATS_W-1:0] t, input logic [BEATS_W-1:0] sp);
    entry_t ctx, b;
    int     n;
    ctx = rand_item(FUNC_WR_CTX);
    ctx.bank        = s;
    ctx.end_bank    = e;
    ctx.total_beats = t;
    ctx.split_beats = sp;
    send_item(ctx, 1'b0);
    write_xfers++;
    n = (t == 0) ? 128 : t;
    for (int c = 1; c <= n; c++) begin
      b = rand_item(FUNC_WR_BEAT);
      b.beat_last = (c == n) || ($urandom_range(0, 3) == 0);
      wr_plan.push_back(b);
    end
  endtask

  task automatic start_read_rand();
    logic [BEATS_W-1:0] t;
    t = pick_total();
    start_read(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), t,
               (t == 0) ? 0 : $urandom_range(1, t));
  endtask

  task automatic start_write_rand();
    logic [BEATS_W-1:0] t, sp;
    if (phase == 2 && !wrapped) begin
      t = '0;
      wrapped = 1'b1;
    end else begin
      t = pick_total();
    end
    if ($urandom_range(0, 4) == 0) sp = 7'($urandom_range(0, 127));
    else sp = 7'($urandom_range(0, t + 1));
    start_write(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), t, sp);
  endtask

  task automatic step_plans();
    if (rd_plan.size() > 0 && (wr_plan.size() == 0 || $urandom_range(0, 1) == 1))
      send_item(rd_plan.pop_front(), 1'b0);
    else
      send_item(wr_plan.pop_front(), 1'b0);
  endtask

  task automatic drain_plans();
    while (rd_plan.size() + wr_plan.size() > 0) step_plans();
  endtask

  // items the block must turn away: busy contexts, off-bank or idle beats
  task automatic send_refused();
    entry_t it;
    if ($urandom_range(0, 1) == 1) begin
      if (rd_plan.size() == 0) begin
        it = rand_item(FUNC_RD_BEAT);
      end else if ($urandom_range(0, 1) == 1) begin
        it = rand_item(FUNC_RD_CTX);
      end else begin
        it = rand_item(FUNC_RD_BEAT);
        it.bank = rd_plan[0].bank + 2'($urandom_range(1, 3));
      end
    end else begin
      it = rand_item((wr_plan.size() == 0) ? FUNC_WR_BEAT : FUNC_WR_CTX);
    end
    send_item(it, 1'b1);
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (rd_plan.size() == 0 && wr_plan.size() == 0) begin
      if (pick < 50) start_read_rand();
      else start_write_rand();
    end else if (rd_plan.size() == 0 && pick < 15) begin
      start_read_rand();
    end else if (wr_plan.size() == 0 && pick < 30) begin
      start_write_rand();
    end else if (pick < 88) begin
      step_plans();
    end else begin
      send_refused();
    end
  endtask

  task automatic directed_items();
    entry_t it;
    // both engines idle: beats are turned away
    it = rand_item(FUNC_RD_BEAT);
    it.beat_data = '1;
    send_item(it, 1'b1);
    it = rand_item(FUNC_WR_BEAT);
    it.beat_data = '0;
    send_item(it, 1'b1);
    // read with early last on the first beat, then two beats from the end bank
    start_read(2'd3, 2'd0, 7'd3, 1);
    rd_plan[0].beat_data = '1;
    rd_plan[1].beat_data = '0;
    it = rand_item(FUNC_RD_CTX);
    it.total_beats = '1;
    it.split_beats = '1;
    send_item(it, 1'b1);
    it = rand_item(FUNC_RD_BEAT);
    it.bank = 2'd1;
    send_item(it, 1'b1);
    drain_plans();
    // write split after one beat
    start_write(2'd2, 2'd1, 7'd3, 7'd1);
    send_item(rand_item(FUNC_WR_CTX), 1'b1);
    drain_plans();
    // zero split: no forced last
    start_write(2'd0, 2'd3, 7'd2, 7'd0);
    drain_plans();
    // read that never crosses to the end bank
    start_read(2'd1, 2'd2, 7'd2, 2);
    drain_plans();
    // split past the total
    start_write(2'd1, 2'd1, 7'd1, 7'd5);
    drain_plans();
  endtask

  initial begin
    rst_ni    <= 1'b0;
    send_idle  = 36;
    recv_idle  = 66;
    hold_asks  = 0;
    phase      = 0;
    wrapped    = 1'b0;
    work_items = 0;
    ignored_items = 0;
    read_xfers    = 0;
    write_xfers   = 0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FUNC_RD_CTX;
    in_ch.bank        <= '0;
    in_ch.end_bank    <= '0;
    in_ch.total_beats <= '0;
    in_ch.split_beats <= '0;
    in_ch.beat_data   <= '0;
    in_ch.beat_last   <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_items();

    while (work_items < WORK_ITEMS) begin
      if (phase == 0 && work_items >= WORK_ITEMS / 3) begin
        phase = 1;
        send_idle = 66;
        recv_idle <= 36;
      end else if (phase == 1 && work_items >= 2 * WORK_ITEMS / 3) begin
        // no idling; the receiver holds off once so the input backs up
        phase = 2;
        send_idle = 0;
        recv_idle <= 0;
        hold_asks <= hold_asks + 1;
      end
      random_step();
    end
    drain_plans();
    in_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items (%0d meant to be turned away), %0d results checked",
             work_items + ignored_items, ignored_items, checked);
    $display("Ran %0d read and %0d write transfers, with bank switches and count wrap",
             read_xfers, write_xfers);
    if (fail_count == 0)
      $display("dram_bank_burst_dispatcher_unit: match");
    else
      $display("dram_bank_burst_dispatcher_unit: mismatch");
    $finish;
  end

endmodule
